/* hw/rtl/cmsd_pkg.sv */
// ----------------------------------------------------------------------------
// cmsd_pkg
// Shared types and constants of the dual counter count-min sketch.
// ----------------------------------------------------------------------------
package cmsd_pkg;

    localparam int unsigned COLUMNS_DEF = 1024;
    localparam int unsigned ROWS_DEF    = 5;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] MIX_K1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_K2    = 64'h94d049bb133111eb;
    localparam logic [31:0] REQ_MAX   = 32'hFFFFFFFF;
    localparam logic [47:0] BYTES_MAX = 48'hFFFFFFFFFFFF;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [31:0] byte_count;
    } cmsd_in_t;

    typedef struct packed {
        logic [63:0] key_hash;
        logic [31:0] min_requests;
        logic [47:0] min_bytes;
    } cmsd_out_t;

    // what one cell hands to the next
    typedef struct packed {
        logic        valid;
        logic        command;
        logic [31:0] byte_count;
        logic [31:0] min_requests;
        logic [47:0] min_bytes;
    } cmsd_link_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIN,
        ST_MOD,
        ST_CHAIN
    } cmsd_state_t;

    // fnv-1a step; the prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {56'd0, b};
        return (x << 40) + (x * 64'h1b3);
    endfunction

endpackage

/* hw/rtl/count_min_sketch_dual_counter_core.sv */
// ----------------------------------------------------------------------------
// count_min_sketch_dual_counter_core
// Count-min sketch with a request and a byte counter per cell, keyed by a
// streamed fnv-1a hash and double hashing over a chain of row cells.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------
//  key      | key_valid / key_ready      | key_word    (cmsd_in_t)
//  result   | result_valid / result_ready| result_word (cmsd_out_t)
//
// a byte that is not last is folded into the running hash as it is taken
// a last byte reaches result_valid through the finalizer, two 64-bit
// multiplies on one 32x32 multiplier, the 4-bit-a-cycle column
// reduction, the chain of row cells and the output register
// after reset the counters are cleared, key_ready low
// the result sits in an output register; new keys stream in meanwhile, only
// a last byte waits until the previous result is taken
// ----------------------------------------------------------------------------
module count_min_sketch_dual_counter_core #(
    parameter int unsigned COLUMNS = cmsd_pkg::COLUMNS_DEF,
    parameter int unsigned ROWS    = cmsd_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_ready,
    input  cmsd_pkg::cmsd_in_t  key_word,
    output logic                result_valid,
    input  logic                result_ready,
    output cmsd_pkg::cmsd_out_t result_word
);
    import cmsd_pkg::*;

    localparam int unsigned CIW     = $clog2(COLUMNS);
    localparam logic [CIW:0] COL_LIM = (CIW+1)'(COLUMNS);
    localparam logic [CIW-1:0] CLR_LAST = CIW'(COLUMNS - 1);

    cmsd_state_t state_reg, state_next;

    logic [63:0] hash_reg;
    logic [63:0] h1_reg;
    logic        cmd_reg;
    logic [31:0] add_reg;
    logic [CIW-1:0] clr_cnt_reg;

    logic [63:0] fin_a_reg, fin_prod_reg, fin_acc_reg;
    logic [1:0]  fin_cnt_reg;
    logic        fin_phase_reg;

    logic [63:0] sh1_reg, sh2_reg;
    logic [CIW-1:0] rem1_reg, rem2_reg;
    logic [3:0]  mod_cnt_reg;
    logic        launch_reg;

    logic        out_valid_reg;
    cmsd_out_t   out_word_reg;

    logic        key_acc, last_acc, fin_done, mod_done;
    logic [63:0] mul_k;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] fin_f;
    logic [CIW-1:0] rem1_nxt, rem2_nxt;

    cmsd_link_t     links [ROWS+1];
    logic [CIW-1:0] cols  [ROWS+1];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        key_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                key_ready = !key_word.key_last || !out_valid_reg;
                if (key_valid && key_ready && key_word.key_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_done)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_CHAIN;
                end
            end
            ST_CHAIN:
            begin
                if (links[ROWS].valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign key_acc  = key_valid && key_ready;
    assign last_acc = key_acc && key_word.key_last;
    assign fin_done = (state_reg == ST_FIN) && (fin_cnt_reg == 2'd3) && fin_phase_reg;
    assign mod_done = (state_reg == ST_MOD) && (mod_cnt_reg == 4'd15);

    // shared 32x32 multiplier, low 64 bits of a 64x64 product in partial products
    always_comb
    begin
        mul_k = fin_phase_reg ? MIX_K2 : MIX_K1;
        case (fin_cnt_reg)
            2'd1:    begin mul_a = fin_a_reg[31:0];  mul_b = mul_k[63:32]; end
            2'd2:    begin mul_a = fin_a_reg[63:32]; mul_b = mul_k[31:0];  end
            default: begin mul_a = fin_a_reg[31:0];  mul_b = mul_k[31:0];  end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
        fin_f = fin_acc_reg + {fin_prod_reg[31:0], 32'd0};
    end

    // column reduction, four hash bits a cycle, msb first
    always_comb
    begin
        logic [CIW:0] t1, t2;
        rem1_nxt = rem1_reg;
        rem2_nxt = rem2_reg;
        for (int i = 0; i < 4; i++)
        begin
            t1 = {rem1_nxt, sh1_reg[63-i]};
            t2 = {rem2_nxt, sh2_reg[63-i]};
            if (t1 >= COL_LIM)
            begin
                t1 = t1 - COL_LIM;
            end
            if (t2 >= COL_LIM)
            begin
                t2 = t2 - COL_LIM;
            end
            rem1_nxt = t1[CIW-1:0];
            rem2_nxt = t2[CIW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_BASIS;
            clr_cnt_reg   <= '0;
            fin_cnt_reg   <= '0;
            fin_phase_reg <= 1'b0;
            mod_cnt_reg   <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= mod_done;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (key_acc)
            begin
                hash_reg <= key_word.key_last ? FNV_BASIS
                                              : fnv_step(hash_reg, key_word.key_byte);
            end
            if (last_acc)
            begin
                fin_cnt_reg   <= '0;
                fin_phase_reg <= 1'b0;
            end
            else if (state_reg == ST_FIN)
            begin
                fin_cnt_reg <= fin_cnt_reg + 2'd1;
                if (fin_cnt_reg == 2'd3)
                begin
                    fin_phase_reg <= 1'b1;
                end
            end
            if (state_reg == ST_MOD)
            begin
                mod_cnt_reg <= mod_cnt_reg + 4'd1;
            end
            else
            begin
                mod_cnt_reg <= '0;
            end
            if (links[ROWS].valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [63:0] h;
        h = fnv_step(hash_reg, key_word.key_byte);
        if (last_acc)
        begin
            h1_reg    <= h;
            cmd_reg   <= key_word.command;
            add_reg   <= key_word.byte_count;
            fin_a_reg <= h ^ (h >> 30);
        end
        if (state_reg == ST_FIN)
        begin
            fin_prod_reg <= mul_p;
            case (fin_cnt_reg)
                2'd1:    fin_acc_reg <= fin_prod_reg;
                2'd2:    fin_acc_reg <= fin_f;
                2'd3:
                begin
                    if (!fin_phase_reg)
                    begin
                        fin_a_reg <= fin_f ^ (fin_f >> 27);
                    end
                    else
                    begin
                        sh1_reg  <= h1_reg;
                        sh2_reg  <= fin_f ^ (fin_f >> 31) | 64'd1;
                        rem1_reg <= '0;
                        rem2_reg <= '0;
                    end
                end
                default: fin_acc_reg <= fin_acc_reg;
            endcase
        end
        if (state_reg == ST_MOD)
        begin
            rem1_reg <= rem1_nxt;
            rem2_reg <= rem2_nxt;
            sh1_reg  <= sh1_reg << 4;
            sh2_reg  <= sh2_reg << 4;
        end
        if (links[ROWS].valid)
        begin
            out_word_reg.key_hash     <= h1_reg;
            out_word_reg.min_requests <= links[ROWS].min_requests;
            out_word_reg.min_bytes    <= links[ROWS].min_bytes;
        end
    end

    // row chain
    assign links[0] = '{valid:        launch_reg,
                        command:      cmd_reg,
                        byte_count:   add_reg,
                        min_requests: REQ_MAX,
                        min_bytes:    BYTES_MAX};
    assign cols[0]  = rem1_reg;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        cmsd_cell #(
            .COLUMNS (COLUMNS),
            .CIW     (CIW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr_en   (state_reg == ST_CLEAR),
            .clr_addr (clr_cnt_reg),
            .link_in  (links[r]),
            .col_in   (cols[r]),
            .col_step (rem2_reg),
            .link_out (links[r+1]),
            .col_out  (cols[r+1])
        );
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

`ifndef ASSERT_OFF
    a_launch_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> state_reg == ST_CHAIN)
        else $error("chain launched outside chain state");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        links[ROWS].valid |-> !out_valid_reg)
        else $error("row minima arrived while output word still held");
    a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        last_acc |=> state_reg == ST_FIN && hash_reg == FNV_BASIS)
        else $error("last byte did not start finalizer");
    a_no_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_ready |-> state_reg == ST_IDLE)
        else $error("key taken while busy");
`endif

endmodule

/* hw/rtl/cmsd_cell.sv */
// ----------------------------------------------------------------------------
// cmsd_cell
// One sketch row: counter memories, saturating update and running minimum.
// ----------------------------------------------------------------------------
module cmsd_cell #(
    parameter int unsigned COLUMNS = cmsd_pkg::COLUMNS_DEF,
    parameter int unsigned CIW     = $clog2(COLUMNS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr_en,
    input  logic [CIW-1:0]       clr_addr,
    input  cmsd_pkg::cmsd_link_t link_in,
    input  logic [CIW-1:0]       col_in,
    input  logic [CIW-1:0]       col_step,
    output cmsd_pkg::cmsd_link_t link_out,
    output logic [CIW-1:0]       col_out
);
    import cmsd_pkg::*;

    localparam logic [CIW:0] COL_LIM = (CIW+1)'(COLUMNS);

    logic [31:0] req_mem [COLUMNS];
    logic [47:0] bytes_mem [COLUMNS];

    logic [31:0] rd_req_reg;
    logic [47:0] rd_bytes_reg;
    logic        s1_valid_reg;
    cmsd_link_t  s1_link_reg;
    logic [CIW-1:0] s1_col_reg;
    logic [CIW-1:0] s1_col_nxt_reg;
    cmsd_link_t  out_link_reg;
    logic [CIW-1:0] out_col_reg;

    logic [CIW:0]   col_sum;
    logic [CIW-1:0] col_nxt;
    logic [31:0] new_req;
    logic [48:0] byte_sum;
    logic [47:0] new_bytes;
    logic [31:0] eff_req;
    logic [47:0] eff_bytes;
    logic        wr_en;

    // next row's column, kept below COLUMNS
    always_comb
    begin
        col_sum = {1'b0, col_in} + {1'b0, col_step};
        if (col_sum >= COL_LIM)
        begin
            col_sum = col_sum - COL_LIM;
        end
        col_nxt = col_sum[CIW-1:0];
    end

    always_comb
    begin
        new_req   = (rd_req_reg == REQ_MAX) ? rd_req_reg : rd_req_reg + 32'd1;
        byte_sum  = {1'b0, rd_bytes_reg} + {17'd0, s1_link_reg.byte_count};
        new_bytes = byte_sum[48] ? BYTES_MAX : byte_sum[47:0];
        wr_en     = s1_valid_reg && (s1_link_reg.command == CMD_UPDATE);
        eff_req   = wr_en ? new_req : rd_req_reg;
        eff_bytes = wr_en ? new_bytes : rd_bytes_reg;
    end

    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            req_mem[clr_addr]   <= '0;
            bytes_mem[clr_addr] <= '0;
        end
        else if (wr_en)
        begin
            req_mem[s1_col_reg]   <= new_req;
            bytes_mem[s1_col_reg] <= new_bytes;
        end
        rd_req_reg   <= req_mem[col_in];
        rd_bytes_reg <= bytes_mem[col_in];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_link_reg <= '0;
        end
        else
        begin
            s1_valid_reg       <= link_in.valid;
            out_link_reg.valid <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_link_reg.command      <= s1_link_reg.command;
                out_link_reg.byte_count   <= s1_link_reg.byte_count;
                out_link_reg.min_requests <= (eff_req < s1_link_reg.min_requests)
                                             ? eff_req : s1_link_reg.min_requests;
                out_link_reg.min_bytes    <= (eff_bytes < s1_link_reg.min_bytes)
                                             ? eff_bytes : s1_link_reg.min_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            s1_link_reg    <= link_in;
            s1_col_reg     <= col_in;
            s1_col_nxt_reg <= col_nxt;
        end
        if (s1_valid_reg)
        begin
            out_col_reg <= s1_col_nxt_reg;
        end
    end

    assign link_out = out_link_reg;
    assign col_out  = out_col_reg;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the dual counter count-min sketch core: keys stream in byte by
// byte with bursty input and a stalling result side, and every result is
// compared against a local sketch that hashes and counts the same keys.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cmsd_pkg::*;

    localparam int unsigned NCOL      = COLUMNS_DEF;
    localparam int unsigned NROW      = ROWS_DEF;
    localparam int unsigned NCELL     = NCOL * NROW;
    localparam logic [63:0] HASH_MULT = 64'h100000001b3;
    localparam int          N_WORDS   = 1300;
    localparam int          TIME_LIMIT = 600000;

    logic      clk;
    logic      rst_n;
    logic      key_valid;
    logic      key_ready;
    cmsd_in_t  key_word;
    logic      result_valid;
    logic      result_ready;
    cmsd_out_t result_word;

    count_min_sketch_dual_counter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .key_word     (key_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    // local sketch
    logic [63:0] hash_acc;
    logic [31:0] req_cnt  [NCELL];
    logic [47:0] byte_cnt [NCELL];

    cmsd_in_t  key_words_pending [$];
    cmsd_out_t sketch_results    [$];
    int        mismatches;
    int        cycle_count;

    function automatic logic [63:0] mix_odd(logic [63:0] v);
        v = v ^ (v >> 30);
        v = v * MIX_K1;
        v = v ^ (v >> 27);
        v = v * MIX_K2;
        v = v ^ (v >> 31);
        return v | 64'd1;
    endfunction

    function automatic void sketch_step(cmsd_in_t w);
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] col;
        logic [48:0] bsum;
        logic [31:0] min_r;
        logic [47:0] min_b;
        int          idx;
        cmsd_out_t   r;
        hash_acc = (hash_acc ^ {56'd0, w.key_byte}) * HASH_MULT;
        if (!w.key_last)
            return;
        h1    = hash_acc;
        h2    = mix_odd(h1);
        min_r = REQ_MAX;
        min_b = BYTES_MAX;
        for (int row = 0; row < NROW; row++)
        begin
            col = (h1 + 64'(row) * h2) % 64'(NCOL);
            idx = int'(col) + row * NCOL;
            if (w.command == CMD_UPDATE)
            begin
                if (req_cnt[idx] != REQ_MAX)
                    req_cnt[idx] = req_cnt[idx] + 32'd1;
                bsum = {1'b0, byte_cnt[idx]} + {17'd0, w.byte_count};
                byte_cnt[idx] = (bsum > {1'b0, BYTES_MAX}) ? BYTES_MAX : bsum[47:0];
            end
            if (req_cnt[idx] < min_r)
                min_r = req_cnt[idx];
            if (byte_cnt[idx] < min_b)
                min_b = byte_cnt[idx];
        end
        r.key_hash     = h1;
        r.min_requests = min_r;
        r.min_bytes    = min_b;
        sketch_results.push_back(r);
        hash_acc = FNV_BASIS;
    endfunction

    function automatic void queue_key(logic [7:0] bytes [$], logic cmd, logic [31:0] cnt);
        cmsd_in_t w;
        foreach (bytes[i])
        begin
            w.key_byte = bytes[i];
            w.key_last = (i == bytes.size() - 1);
            // command and count only matter on the last byte
            w.command    = w.key_last ? cmd : 1'($urandom);
            w.byte_count = w.key_last ? cnt : $urandom;
            key_words_pending.push_back(w);
        end
    endfunction

    function automatic logic [31:0] random_count();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFFFFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 1500);
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        logic [7:0] pool [8][$];
        logic [7:0] k [$];
        int         p;
        hash_acc   = FNV_BASIS;
        mismatches = 0;
        for (int i = 0; i < NCELL; i++)
        begin
            req_cnt[i]  = '0;
            byte_cnt[i] = '0;
        end

        // directed keys: unseen query, byte extremes, count extremes, repeats
        queue_key('{8'h00}, CMD_QUERY, 32'd7);
        queue_key('{8'h00}, CMD_UPDATE, 32'd0);
        queue_key('{8'hFF}, CMD_UPDATE, 32'hFFFFFFFF);
        queue_key('{8'hFF}, CMD_UPDATE, 32'hFFFFFFFF);
        queue_key('{8'hFF}, CMD_QUERY, 32'd0);
        queue_key('{8'h00}, CMD_QUERY, 32'hFFFFFFFF);
        queue_key('{8'h61, 8'h62, 8'h63}, CMD_UPDATE, 32'd100);
        queue_key('{8'h61, 8'h62, 8'h63}, CMD_UPDATE, 32'd23);
        queue_key('{8'h61, 8'h62, 8'h63}, CMD_QUERY, 32'd0);
        queue_key('{8'h55, 8'hAA}, CMD_QUERY, 32'd1);

        for (int i = 0; i < 8; i++)
        begin
            pool[i] = {};
            for (int j = 0; j < $urandom_range(1, 6); j++)
                pool[i].push_back(8'($urandom));
        end
        while (key_words_pending.size() < N_WORDS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                p = $urandom_range(0, 7);
                k = pool[p];
            end
            else
            begin
                k = {};
                for (int j = 0; j < $urandom_range(1, 12); j++)
                    k.push_back(8'($urandom));
            end
            queue_key(k, ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_UPDATE,
                      random_count());
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (key_words_pending.size() == 0 && !key_valid);
        wait (sketch_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid  <= 1'b0;
            key_word   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (key_valid && key_ready)
                sketch_step(key_word);
            if (!key_valid || key_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    key_valid <= 1'b0;
                end
                else if (key_words_pending.size() > 0)
                begin
                    key_word  <= key_words_pending.pop_front();
                    key_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    key_valid <= 1'b0;
            end
        end
    end

    // receiver: alternating stretches of steady ready and random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            cycle_count  <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= TIME_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if ((cycle_count / 300) % 3 == 0)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(0, 3) != 0) && (cycle_count % 7 != 3);

            if (result_valid && result_ready)
            begin
                if (sketch_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word: %h", result_word);
                end
                else
                begin
                    cmsd_out_t e;
                    e = sketch_results.pop_front();
                    if (e.key_hash != result_word.key_hash
                        || e.min_requests != result_word.min_requests
                        || e.min_bytes != result_word.min_bytes)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: hash %h/%h requests %0d/%0d bytes %0d/%0d",
                                     e.key_hash, result_word.key_hash,
                                     e.min_requests, result_word.min_requests,
                                     e.min_bytes, result_word.min_bytes);
                    end
                end
            end
        end
    end

endmodule

/* sim.f */
hw/rtl/cmsd_pkg.sv
hw/rtl/cmsd_cell.sv
hw/rtl/count_min_sketch_dual_counter_core.sv
tb/tb_top.sv
